// ===== src/rbd_pkg.sv =====
package rbd_pkg;

    // Sizing
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_TIERS  = 3;
    localparam int STOP_SIZE  = 16;

    // Field widths
    localparam int DIM_W      = 13;
    localparam int CH_W       = 8;
    localparam int SUM_CH_W   = CH_W + 1;
    localparam int SUM_W      = 4 * SUM_CH_W;
    localparam int TIER_REG_W = 2;
    localparam int TIER_CNT_W = $clog2(MAX_TIERS + 1);

    // Line store address width, sized for the first (widest) tier
    localparam int LINE_AW    = $clog2(MAX_WIDTH / 2);

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUALITY_TIER  = 2'd2;

    typedef logic [3:0][CH_W-1:0]     chan_t;
    typedef logic [3:0][SUM_CH_W-1:0] sum_t;

    // One pixel moving between tiers
    typedef struct packed {
        chan_t ch;
        logic  last;
    } pixel_t;

    // Static settings of one tier
    typedef struct packed {
        logic             active;
        logic             count_last;
        logic             restart;
        logic [DIM_W-1:0] w_in;
        logic [DIM_W-1:0] h_in;
        logic [DIM_W-1:0] w_out;
        logic [DIM_W-1:0] h_out;
    } tier_cfg_t;

    // Line store access of one tier
    typedef struct packed {
        logic               we;
        logic               re;
        logic [LINE_AW-1:0] addr;
        sum_t               wdata;
    } ram_req_t;

    // Image sizes at every tier and the number of halvings in use
    typedef struct packed {
        logic [MAX_TIERS:0][DIM_W-1:0] dim_w;
        logic [MAX_TIERS:0][DIM_W-1:0] dim_h;
        logic [TIER_CNT_W-1:0]         active;
    } plan_t;

    function automatic plan_t plan_tiers(input logic [DIM_W-1:0] w_reg,
                                         input logic [DIM_W-1:0] h_reg,
                                         input logic [TIER_REG_W-1:0] tier_reg);
        plan_t            p;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        int               tiers;
        int               n;
        logic             stop;
        // zero reads as one, width saturates
        w = w_reg;
        if (w_reg == '0)
            w = DIM_W'(1);
        else if (int'(w_reg) > MAX_WIDTH)
            w = DIM_W'(MAX_WIDTH);
        h = (h_reg == '0) ? DIM_W'(1) : h_reg;
        tiers = (int'(tier_reg) > MAX_TIERS) ? MAX_TIERS : int'(tier_reg);
        n = 0;
        stop = 1'b0;
        p.dim_w[0] = w;
        p.dim_h[0] = h;
        for (int s = 0; s < MAX_TIERS; s++) begin
            if (!stop && s < tiers && !(w <= STOP_SIZE && h <= STOP_SIZE)) begin
                w = ((w >> 1) == '0) ? DIM_W'(1) : (w >> 1);
                h = ((h >> 1) == '0) ? DIM_W'(1) : (h >> 1);
                n = s + 1;
            end else begin
                stop = 1'b1;
            end
            p.dim_w[s+1] = stop ? DIM_W'(1) : w;
            p.dim_h[s+1] = stop ? DIM_W'(1) : h;
        end
        p.active = TIER_CNT_W'(n);
        return p;
    endfunction

endpackage

// ===== src/rgba_box_downscale.sv =====
// Pipeline: an input register, then a middle and an output register in each of
// 3 tiers. Throughput: one source pixel per clock while out_ready does not
// hold the output back; each tier's single-port line store takes one read or
// one write per cycle.
// Reset: clears all valid flags and raster positions; registers return to
// width 1, height 1, tier 0. Line stores are not cleared.
module rgba_box_downscale
    import rbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CH_W-1:0]      red_in,
    input  logic [CH_W-1:0]      green_in,
    input  logic [CH_W-1:0]      blue_in,
    input  logic [CH_W-1:0]      alpha_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CH_W-1:0]      red_out,
    output logic [CH_W-1:0]      green_out,
    output logic [CH_W-1:0]      blue_out,
    output logic [CH_W-1:0]      alpha_out,
    output logic                 image_done
);

    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [TIER_REG_W-1:0] tier_reg;
    logic                  restart;
    plan_t                 plan;

    logic                  in_valid_reg;
    pixel_t                in_pix_reg;
    logic                  in_load;

    logic      [MAX_TIERS:0] st_valid;
    logic      [MAX_TIERS:0] st_ready;
    pixel_t                  st_pix [MAX_TIERS+1];
    tier_cfg_t               tier_cfg [MAX_TIERS];
    ram_req_t                ram_req [MAX_TIERS];
    sum_t                    ram_rdata [MAX_TIERS];

    // Configuration writes; an unknown index is taken and ignored
    assign cfg_ready = 1'b1;

    always_comb
    begin
        case (cfg_index)
            REG_SOURCE_WIDTH:  restart = cfg_valid;
            REG_SOURCE_HEIGHT: restart = cfg_valid;
            REG_QUALITY_TIER:  restart = cfg_valid;
            default:           restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            tier_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  width_reg  <= cfg_data;
                REG_SOURCE_HEIGHT: height_reg <= cfg_data;
                REG_QUALITY_TIER:  tier_reg   <= cfg_data[TIER_REG_W-1:0];
                default:           ;
            endcase
        end
    end

    assign plan = plan_tiers(width_reg, height_reg, tier_reg);

    // Input register
    assign in_load  = !in_valid_reg || st_ready[0];
    assign in_ready = in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_load)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_valid) begin
            in_pix_reg.ch[0] <= red_in;
            in_pix_reg.ch[1] <= green_in;
            in_pix_reg.ch[2] <= blue_in;
            in_pix_reg.ch[3] <= alpha_in;
            in_pix_reg.last  <= 1'b0;
        end
    end

    assign st_valid[0] = in_valid_reg;
    assign st_pix[0]   = in_pix_reg;

    // Tier cascade, each with its own line store
    for (genvar s = 0; s < MAX_TIERS; s++) begin : g_tier
        localparam int DEPTH = ((MAX_WIDTH >> (s + 1)) < 1) ? 1 : (MAX_WIDTH >> (s + 1));
        localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

        assign tier_cfg[s].active     = plan.active > TIER_CNT_W'(s);
        assign tier_cfg[s].count_last = (s == 0) && (plan.active == '0);
        assign tier_cfg[s].restart    = restart;
        assign tier_cfg[s].w_in       = plan.dim_w[s];
        assign tier_cfg[s].h_in       = plan.dim_h[s];
        assign tier_cfg[s].w_out      = plan.dim_w[s+1];
        assign tier_cfg[s].h_out      = plan.dim_h[s+1];

        rbd_tier u_tier (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg       (tier_cfg[s]),
            .in_valid  (st_valid[s]),
            .in_ready  (st_ready[s]),
            .in_pix    (st_pix[s]),
            .out_valid (st_valid[s+1]),
            .out_ready (st_ready[s+1]),
            .out_pix   (st_pix[s+1]),
            .ram_req   (ram_req[s]),
            .ram_rdata (ram_rdata[s])
        );

        rbd_ram #(
            .WIDTH (SUM_W),
            .DEPTH (DEPTH)
        ) u_line (
            .clk   (clk),
            .we    (ram_req[s].we),
            .re    (ram_req[s].re),
            .addr  (ram_req[s].addr[AW-1:0]),
            .wdata (ram_req[s].wdata),
            .rdata (ram_rdata[s])
        );
    end

    // Result channel
    assign st_ready[MAX_TIERS] = out_ready;
    assign out_valid  = st_valid[MAX_TIERS];
    assign red_out    = st_pix[MAX_TIERS].ch[0];
    assign green_out  = st_pix[MAX_TIERS].ch[1];
    assign blue_out   = st_pix[MAX_TIERS].ch[2];
    assign alpha_out  = st_pix[MAX_TIERS].ch[3];
    assign image_done = st_pix[MAX_TIERS].last;

endmodule

// ===== src/rbd_ram.sv =====
module rbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                     wdata,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata <= mem[addr];
    end

endmodule

// ===== src/rbd_tier.sv =====
module rbd_tier
    import rbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tier_cfg_t cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  pixel_t    in_pix,
    output logic      out_valid,
    input  logic      out_ready,
    output pixel_t    out_pix,
    output ram_req_t  ram_req,
    input  sum_t      ram_rdata
);

    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    chan_t            hold_reg;

    logic             mid_valid_reg;
    sum_t             mid_q_reg;
    logic [1:0]       mid_shift_reg;
    logic             mid_line_reg;
    logic             mid_last_reg;

    logic             out_valid_reg;
    pixel_t           out_pix_reg;

    logic             out_load, mid_load, entry_fire, counting;
    logic [DIM_W-1:0] x, y;
    logic             hpair, vpair, drop, take_hold, take_line;
    logic             emit, last;
    logic [1:0]       shift;
    sum_t             q;
    chan_t            res;

    // Handshake chain
    assign out_load   = !out_valid_reg || out_ready;
    assign mid_load   = !mid_valid_reg || out_load;
    assign in_ready   = mid_load;
    assign entry_fire = in_valid && mid_load;
    assign counting   = cfg.active || cfg.count_last;

    // Position within the tier's input image
    assign x         = col_reg >> 1;
    assign y         = row_reg >> 1;
    assign hpair     = cfg.w_in > DIM_W'(1);
    assign vpair     = cfg.h_in > DIM_W'(1);
    assign drop      = (x >= cfg.w_out) || (y >= cfg.h_out);
    assign take_hold = hpair && !col_reg[0];
    assign take_line = vpair && !row_reg[0];

    // Entry: horizontal pair sum and decisions
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            q[k] = {1'b0, in_pix.ch[k]} + (hpair ? {1'b0, hold_reg[k]} : SUM_CH_W'(0));
        if (cfg.active) begin
            emit  = !drop && !take_hold && !take_line;
            last  = (((DIM_W+1)'(x) + (DIM_W+1)'(1)) == (DIM_W+1)'(cfg.w_out)) &&
                    (((DIM_W+1)'(y) + (DIM_W+1)'(1)) == (DIM_W+1)'(cfg.h_out));
            shift = {1'b0, hpair} + {1'b0, vpair};
        end else begin
            for (int k = 0; k < 4; k++)
                q[k] = {1'b0, in_pix.ch[k]};
            emit  = 1'b1;
            shift = 2'd0;
            if (cfg.count_last)
                last = (((DIM_W+1)'(col_reg) + (DIM_W+1)'(1)) == (DIM_W+1)'(cfg.w_in)) &&
                       (((DIM_W+1)'(row_reg) + (DIM_W+1)'(1)) == (DIM_W+1)'(cfg.h_in));
            else
                last = in_pix.last;
        end
    end

    // Line store: write on even rows, read on odd rows
    assign ram_req.we    = entry_fire && cfg.active && !drop && !take_hold && take_line;
    assign ram_req.re    = entry_fire && cfg.active && emit && vpair;
    assign ram_req.addr  = x[LINE_AW-1:0];
    assign ram_req.wdata = q;

    // Raster counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (((DIM_W+1)'(col_reg) + (DIM_W+1)'(1)) >= (DIM_W+1)'(cfg.w_in)) begin
            col_next = '0;
            if (((DIM_W+1)'(row_reg) + (DIM_W+1)'(1)) >= (DIM_W+1)'(cfg.h_in))
                row_next = '0;
            else
                row_next = row_reg + DIM_W'(1);
        end else begin
            col_next = col_reg + DIM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg.restart) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (entry_fire && counting) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Left pixel of a horizontal pair
    always_ff @(posedge clk)
    begin
        if (entry_fire && cfg.active && !drop && take_hold)
            hold_reg <= in_pix.ch;
    end

    // Middle register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_valid_reg <= 1'b0;
        else if (mid_load)
            mid_valid_reg <= entry_fire && emit;
    end

    always_ff @(posedge clk)
    begin
        if (entry_fire && emit) begin
            mid_q_reg     <= q;
            mid_shift_reg <= shift;
            mid_line_reg  <= cfg.active && vpair;
            mid_last_reg  <= last;
        end
    end

    // Vertical sum and truncating average
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            res[k] = CH_W'(({1'b0, mid_q_reg[k]} +
                     (mid_line_reg ? {1'b0, ram_rdata[k]} : (SUM_CH_W+1)'(0)))
                     >> mid_shift_reg);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= mid_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && mid_valid_reg) begin
            out_pix_reg.ch   <= res;
            out_pix_reg.last <= mid_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;

    // Checks
    a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.we && ram_req.re))
        else $error("line store written and read in the same cycle");

    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mid_valid_reg && !out_load |=> mid_valid_reg && $stable(mid_q_reg))
        else $error("stalled middle stage lost its sum");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        counting |-> (col_reg < cfg.w_in) && (row_reg < cfg.h_in))
        else $error("raster position outside the tier image");

    a_pass_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        entry_fire && !cfg.active && !cfg.count_last |=> mid_valid_reg)
        else $error("bypassed tier dropped a pixel");

endmodule
